/* design/dtq_pkg.sv */
// Shared constants, codes and control types of the deadline timer queue.
`timescale 1ns / 1ps
`default_nettype none

package dtq_pkg;

  localparam int TIMER_SLOTS = 32;
  localparam int TIME_BITS   = 48;
  localparam int SLOT_BITS   = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_BITS    = $clog2(TIMER_SLOTS + 1);
  localparam int TICKET_BITS = 32;
  localparam int HANDLE_BITS = 5;
  localparam int FIELD_TIME_BITS = 48;

  typedef logic [SLOT_BITS-1:0]   slot_t;
  typedef logic [CNT_BITS-1:0]    cnt_t;
  typedef logic [TIME_BITS-1:0]   time_t;
  typedef logic [TICKET_BITS-1:0] ticket_t;
  typedef logic [HANDLE_BITS-1:0] handle_t;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_STOP   = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_code_t;

  typedef enum logic [2:0] {
    KIND_ADDED        = 3'd0,
    KIND_ADD_REJECTED = 3'd1,
    KIND_STOPPED      = 3'd2,
    KIND_STOP_REFUSED = 3'd3,
    KIND_FIRED        = 3'd4,
    KIND_NONE_FIRED   = 3'd5
  } kind_t;

  typedef struct packed {
    logic load;
    logic single;
    logic promote;
    logic scan_start;
    logic fire;
  } dtq_cmd_t;

  typedef struct packed {
    logic out_free;
    logic scan_done;
    logic last_fire;
  } dtq_status_t;

endpackage

`default_nettype wire

/* design/dtq_datapath.sv */
// Slot state, deadline and ticket stores, selection scan and result register.
`timescale 1ns / 1ps
`default_nettype none

module dtq_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire dtq_pkg::dtq_cmd_t    cmd,
  output dtq_pkg::dtq_status_t      status,
  input  wire logic [1:0]           command,
  input  wire logic [4:0]           timer_handle,
  input  wire logic [47:0]          deadline,
  input  wire logic [47:0]          now,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output logic [2:0]                kind,
  output logic [4:0]                fired_handle,
  output logic                      was_cancelled,
  output logic                      last
);

  localparam dtq_pkg::slot_t LastSlot = dtq_pkg::slot_t'(dtq_pkg::TIMER_SLOTS - 1);

  logic [1:0]                       cmd_r;
  dtq_pkg::handle_t                 handle_r;
  dtq_pkg::time_t                   deadline_r;
  dtq_pkg::time_t                   now_r;

  logic [dtq_pkg::TIMER_SLOTS-1:0]  pend;
  logic [dtq_pkg::TIMER_SLOTS-1:0]  run;
  logic [dtq_pkg::TIMER_SLOTS-1:0]  live;
  dtq_pkg::ticket_t                 next_ticket;

  dtq_pkg::time_t                   mem_deadline [dtq_pkg::TIMER_SLOTS];
  dtq_pkg::ticket_t                 mem_ticket   [dtq_pkg::TIMER_SLOTS];

  logic                             issuing;
  dtq_pkg::slot_t                   iss_idx;
  logic                             dv;
  dtq_pkg::slot_t                   d_idx;
  logic                             done;
  dtq_pkg::time_t                   rd_deadline;
  dtq_pkg::ticket_t                 rd_ticket;
  logic                             mode_pend;
  logic                             best_valid;
  dtq_pkg::slot_t                   best_idx;
  dtq_pkg::time_t                   best_deadline;
  dtq_pkg::ticket_t                 best_age;
  dtq_pkg::cnt_t                    cnt;

  logic                             clr;
  logic                             in_range;
  dtq_pkg::slot_t                   h_slot;
  logic                             add_ok;
  logic                             stop_ok;
  dtq_pkg::ticket_t                 age;
  logic                             d_pend;
  logic                             d_run;
  logic                             due;
  logic                             elig;
  logic                             cand;
  logic                             better;

  always_comb begin
    clr      = (cmd_r == dtq_pkg::CMD_CLEAR);
    h_slot   = dtq_pkg::slot_t'(handle_r);
    in_range = (32'(handle_r) < 32'(dtq_pkg::TIMER_SLOTS));
    add_ok   = in_range && !pend[h_slot] && !run[h_slot];
    stop_ok  = in_range && live[h_slot];
    age      = next_ticket - rd_ticket;
    d_pend   = pend[d_idx];
    d_run    = run[d_idx];
    due      = clr || (rd_deadline <= now_r);
    elig     = d_pend || (d_run && due);
    cand     = mode_pend ? d_pend : (d_run && due);
    if (!best_valid) begin
      better = 1'b1;
    end else if (mode_pend) begin
      better = (age > best_age);
    end else begin
      better = (rd_deadline < best_deadline) ||
               ((rd_deadline == best_deadline) && (age > best_age));
    end
  end

  assign status.out_free  = !out_valid || !out_stall;
  assign status.scan_done = done;
  assign status.last_fire = !best_valid || (cnt == dtq_pkg::cnt_t'(1));

  always_ff @(posedge clk) begin
    if (cmd.single && (cmd_r == dtq_pkg::CMD_ADD) && add_ok) begin
      mem_deadline[h_slot] <= deadline_r;
      mem_ticket[h_slot]   <= next_ticket;
    end
    if (issuing) begin
      rd_deadline <= mem_deadline[iss_idx];
      rd_ticket   <= mem_ticket[iss_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend        <= '0;
      run         <= '0;
      live        <= '0;
      next_ticket <= '0;
      out_valid   <= 1'b0;
      issuing     <= 1'b0;
      iss_idx     <= '0;
      dv          <= 1'b0;
      done        <= 1'b0;
      mode_pend   <= 1'b0;
      best_valid  <= 1'b0;
      cnt         <= '0;
    end else begin
      if (cmd.single || cmd.fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.single) begin
        if (cmd_r == dtq_pkg::CMD_ADD) begin
          if (add_ok) begin
            pend[h_slot] <= 1'b1;
            live[h_slot] <= 1'b1;
            next_ticket  <= next_ticket + dtq_pkg::ticket_t'(1);
          end
        end else if (stop_ok) begin
          live[h_slot] <= 1'b0;
        end
      end
      if (cmd.promote && !clr) begin
        run  <= run | (pend & live);
        pend <= pend & ~live;
      end
      if (cmd.scan_start) begin
        issuing    <= 1'b1;
        iss_idx    <= '0;
        dv         <= 1'b0;
        done       <= 1'b0;
        best_valid <= 1'b0;
        cnt        <= '0;
        mode_pend  <= |pend;
      end else begin
        if (issuing) begin
          iss_idx <= iss_idx + dtq_pkg::slot_t'(1);
          if (iss_idx == LastSlot) begin
            issuing <= 1'b0;
          end
        end
        dv <= issuing;
        if (dv) begin
          cnt <= cnt + dtq_pkg::cnt_t'(elig);
          if (cand && better) begin
            best_valid <= 1'b1;
          end
          if (d_idx == LastSlot) begin
            done <= 1'b1;
          end
        end
      end
      if (cmd.fire) begin
        if (best_valid) begin
          pend[best_idx] <= 1'b0;
          run[best_idx]  <= 1'b0;
          live[best_idx] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r      <= command;
      handle_r   <= timer_handle;
      deadline_r <= dtq_pkg::time_t'(deadline);
      now_r      <= dtq_pkg::time_t'(now);
    end
    d_idx <= iss_idx;
    if (dv && cand && better) begin
      best_idx      <= d_idx;
      best_deadline <= rd_deadline;
      best_age      <= age;
    end
    if (cmd.single) begin
      if (cmd_r == dtq_pkg::CMD_ADD) begin
        kind <= add_ok ? dtq_pkg::KIND_ADDED : dtq_pkg::KIND_ADD_REJECTED;
      end else begin
        kind <= stop_ok ? dtq_pkg::KIND_STOPPED : dtq_pkg::KIND_STOP_REFUSED;
      end
      fired_handle  <= handle_r;
      was_cancelled <= 1'b0;
      last          <= 1'b1;
    end
    if (cmd.fire) begin
      if (best_valid) begin
        kind          <= dtq_pkg::KIND_FIRED;
        fired_handle  <= dtq_pkg::handle_t'(best_idx);
        was_cancelled <= mode_pend || clr || !live[best_idx];
        last          <= (cnt == dtq_pkg::cnt_t'(1));
      end else begin
        kind          <= dtq_pkg::KIND_NONE_FIRED;
        fired_handle  <= '0;
        was_cancelled <= 1'b0;
        last          <= 1'b1;
      end
    end
  end

  a_phase_exclusive: assert property (@(posedge clk) disable iff (rst)
    (pend & run) == '0)
    else $error("slot both pending and running");

  a_live_queued: assert property (@(posedge clk) disable iff (rst)
    (live & ~(pend | run)) == '0)
    else $error("live slot not queued");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.single || cmd.fire) |-> status.out_free)
    else $error("result word loaded over an untaken word");

  a_fired_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.fire && best_valid) |=> (!pend[$past(best_idx)] && !run[$past(best_idx)] &&
                                  out_valid && (kind == dtq_pkg::KIND_FIRED)))
    else $error("fired slot still queued");

endmodule

`default_nettype wire

/* design/dtq_ctrl.sv */
// Command sequencer of the deadline timer queue.
`timescale 1ns / 1ps
`default_nettype none

module dtq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic [1:0]           command,
  input  wire dtq_pkg::dtq_status_t status,
  output dtq_pkg::dtq_cmd_t         cmd,
  output logic                      in_stall
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SINGLE,
    S_PROMOTE,
    S_INIT,
    S_SCAN,
    S_FIRE
  } state_t;

  state_t state;
  state_t state_next;
  logic   single_cmd;

  always_comb begin
    single_cmd = (command == dtq_pkg::CMD_ADD) || (command == dtq_pkg::CMD_STOP);
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load   = 1'b1;
          state_next = single_cmd ? S_SINGLE : S_PROMOTE;
        end
      end
      S_SINGLE: begin
        if (status.out_free) begin
          cmd.single = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_PROMOTE: begin
        cmd.promote = 1'b1;
        state_next  = S_INIT;
      end
      S_INIT: begin
        cmd.scan_start = 1'b1;
        state_next     = S_SCAN;
      end
      S_SCAN: begin
        if (status.scan_done) begin
          state_next = S_FIRE;
        end
      end
      S_FIRE: begin
        if (status.out_free) begin
          cmd.fire   = 1'b1;
          state_next = status.last_fire ? S_IDLE : S_INIT;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_stall <= 1'b1;
    end else begin
      state    <= state_next;
      in_stall <= (state_next != S_IDLE);
    end
  end

endmodule

`default_nettype wire

/* design/deadline_timer_queue.sv */
// Top level of the deadline timer queue: sequencer and datapath.
// Add and stop: one result word, loaded once the output register is free after the word is taken.
// Update and clear: a promote step, then one scan of the slot store per result word
// (one scan per fired timer), at least one word; the next command is taken
// once the final result word is loaded. One command is handled at a time.
// Synchronous reset empties every slot and zeroes the ticket counter at once.
`timescale 1ns / 1ps
`default_nettype none

module deadline_timer_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [4:0]  timer_handle,
  input  wire logic [47:0] deadline,
  input  wire logic [47:0] now,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       kind,
  output logic [4:0]       fired_handle,
  output logic             was_cancelled,
  output logic             last
);

  dtq_pkg::dtq_cmd_t    cmd;
  dtq_pkg::dtq_status_t status;

  dtq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  dtq_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .command       (command),
    .timer_handle  (timer_handle),
    .deadline      (deadline),
    .now           (now),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .kind          (kind),
    .fired_handle  (fired_handle),
    .was_cancelled (was_cancelled),
    .last          (last)
  );

endmodule

`default_nettype wire

/* test/tb_deadline_timer_queue.sv */
// Self-checking testbench of the deadline timer queue: table-driven and random command words.
`timescale 1ns / 1ps

module tb_deadline_timer_queue;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 60;
  localparam int RANDOM_PER_PHASE = 32;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PENDING = 2'd1,
    PH_RUNNING = 2'd2
  } slot_phase_t;

  typedef struct {
    dtq_pkg::kind_t   kind;
    dtq_pkg::handle_t handle;
    logic             cancelled;
    logic             last;
  } result_t;

  typedef struct {
    dtq_pkg::cmd_code_t cmd;
    dtq_pkg::handle_t   handle;
    dtq_pkg::time_t     dl;
    dtq_pkg::time_t     nw;
    bit                 typed;
    dtq_pkg::kind_t     kind;
  } plan_row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [1:0]    command = dtq_pkg::CMD_ADD;
  logic [4:0]    timer_handle = '0;
  logic [47:0]   deadline = '0;
  logic [47:0]   now = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [2:0]    kind;
  logic [4:0]    fired_handle;
  logic          was_cancelled;
  logic          last;

  slot_phase_t      phase_of  [dtq_pkg::TIMER_SLOTS];
  logic             armed     [dtq_pkg::TIMER_SLOTS];
  dtq_pkg::time_t   due_at    [dtq_pkg::TIMER_SLOTS];
  dtq_pkg::ticket_t ticket_of [dtq_pkg::TIMER_SLOTS];
  dtq_pkg::ticket_t ticket_next;

  result_t       burst[$];
  result_t       due_results[$];
  plan_row_t     plan[$];

  int            idle_pct = 0;
  int            stall_pct = 0;
  int            errors = 0;
  int            words_sent = 0;
  int            results_seen = 0;
  int            fired_seen = 0;
  int            quiet_cycles = 0;

  deadline_timer_queue dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .timer_handle  (timer_handle),
    .deadline      (deadline),
    .now           (now),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .fired_handle  (fired_handle),
    .was_cancelled (was_cancelled),
    .last          (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic dtq_pkg::ticket_t age_of(int s);
    return dtq_pkg::ticket_t'(ticket_next - ticket_of[s]);
  endfunction

  function automatic int oldest_pending();
    int best;
    best = -1;
    for (int i = 0; i < dtq_pkg::TIMER_SLOTS; i++) begin
      if (phase_of[i] == PH_PENDING && (best < 0 || age_of(i) > age_of(best))) best = i;
    end
    return best;
  endfunction

  function automatic int earliest_running(bit all, dtq_pkg::time_t nw);
    int best;
    best = -1;
    for (int i = 0; i < dtq_pkg::TIMER_SLOTS; i++) begin
      if (phase_of[i] != PH_RUNNING) continue;
      if (!all && due_at[i] > nw) continue;
      if (best < 0 || due_at[i] < due_at[best] ||
          (due_at[i] == due_at[best] && age_of(i) > age_of(best))) best = i;
    end
    return best;
  endfunction

  function automatic void add_burst(dtq_pkg::kind_t k, dtq_pkg::handle_t h, logic c);
    result_t w;
    w.kind      = k;
    w.handle    = h;
    w.cancelled = c;
    w.last      = 1'b0;
    burst.insert(burst.size(), w);
  endfunction

  function automatic void fire_slot(int s, logic cancelled);
    add_burst(dtq_pkg::KIND_FIRED, dtq_pkg::handle_t'(s), cancelled);
    phase_of[s] = PH_IDLE;
    armed[s] = 1'b0;
  endfunction

  function automatic void apply_command(dtq_pkg::cmd_code_t c, dtq_pkg::handle_t h,
                                        dtq_pkg::time_t dl, dtq_pkg::time_t nw);
    int  s;
    bit  clr;
    burst.delete();
    case (c)
      dtq_pkg::CMD_ADD: begin
        if (phase_of[h] == PH_PENDING || phase_of[h] == PH_RUNNING) begin
          add_burst(dtq_pkg::KIND_ADD_REJECTED, h, 1'b0);
        end else begin
          phase_of[h] = PH_PENDING;
          armed[h] = 1'b1;
          due_at[h] = dl;
          ticket_of[h] = ticket_next;
          ticket_next = ticket_next + 1;
          add_burst(dtq_pkg::KIND_ADDED, h, 1'b0);
        end
      end
      dtq_pkg::CMD_STOP: begin
        if (armed[h]) begin
          armed[h] = 1'b0;
          add_burst(dtq_pkg::KIND_STOPPED, h, 1'b0);
        end else begin
          add_burst(dtq_pkg::KIND_STOP_REFUSED, h, 1'b0);
        end
      end
      default: begin
        clr = (c == dtq_pkg::CMD_CLEAR);
        for (s = oldest_pending(); s >= 0; s = oldest_pending()) begin
          if (!clr && armed[s]) phase_of[s] = PH_RUNNING;
          else fire_slot(s, 1'b1);
        end
        for (s = earliest_running(clr, nw); s >= 0; s = earliest_running(clr, nw))
          fire_slot(s, clr || !armed[s]);
        if (burst.size() == 0) add_burst(dtq_pkg::KIND_NONE_FIRED, '0, 1'b0);
      end
    endcase
    burst[burst.size()-1].last = 1'b1;
  endfunction

  function automatic plan_row_t row(dtq_pkg::cmd_code_t c, int h, dtq_pkg::time_t dl,
                                    dtq_pkg::time_t nw, bit typed, dtq_pkg::kind_t k);
    return '{c, dtq_pkg::handle_t'(h), dl, nw, typed, k};
  endfunction

  function automatic void add_row(dtq_pkg::cmd_code_t c, int h, dtq_pkg::time_t dl,
                                  dtq_pkg::time_t nw, bit typed, dtq_pkg::kind_t k);
    plan.insert(plan.size(), row(c, h, dl, nw, typed, k));
  endfunction

  function automatic dtq_pkg::time_t rand_tick();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[dtq_pkg::TIME_BITS-1:0];
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (errors < 40)
      $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic send_word(plan_row_t r);
    result_t w;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= r.cmd;
    timer_handle <= r.handle;
    deadline     <= r.dl;
    now          <= r.nw;
    do @(posedge clk); while (in_stall);
    words_sent++;
    apply_command(r.cmd, r.handle, r.dl, r.nw);
    if (r.typed) begin
      w.kind      = r.kind;
      w.handle    = r.handle;
      w.cancelled = 1'b0;
      w.last      = 1'b1;
      due_results.insert(due_results.size(), w);
    end else begin
      foreach (burst[i]) due_results.insert(due_results.size(), burst[i]);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  task automatic random_words(int count, ref dtq_pkg::time_t wall);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_word(row(dtq_pkg::CMD_ADD, $urandom_range(0, dtq_pkg::TIMER_SLOTS - 1),
                      ($urandom_range(0, 9) == 0) ? rand_tick()
                        : wall + (($urandom_range(0, 1) == 0) ? $urandom_range(0, 300)
                                                              : 50 * $urandom_range(0, 3)),
                      rand_tick(), 1'b0, dtq_pkg::KIND_ADDED));
      end else if (r < 65) begin
        send_word(row(dtq_pkg::CMD_STOP, $urandom_range(0, dtq_pkg::TIMER_SLOTS - 1),
                      rand_tick(), rand_tick(), 1'b0, dtq_pkg::KIND_ADDED));
      end else if (r < 95) begin
        wall = wall + $urandom_range(0, 150);
        send_word(row(dtq_pkg::CMD_UPDATE, $urandom_range(0, dtq_pkg::TIMER_SLOTS - 1),
                      rand_tick(), ($urandom_range(0, 19) == 0) ? rand_tick() : wall,
                      1'b0, dtq_pkg::KIND_ADDED));
      end else begin
        send_word(row(dtq_pkg::CMD_CLEAR, $urandom_range(0, dtq_pkg::TIMER_SLOTS - 1),
                      rand_tick(), rand_tick(), 1'b0, dtq_pkg::KIND_ADDED));
      end
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (kind == dtq_pkg::KIND_FIRED) fired_seen++;
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result kind", kind, -1);
      end else begin
        want = due_results.pop_front();
        if (kind != want.kind) report_mismatch("kind", kind, want.kind);
        if (fired_handle != want.handle) report_mismatch("fired_handle", fired_handle, want.handle);
        if (was_cancelled != want.cancelled)
          report_mismatch("was_cancelled", was_cancelled, want.cancelled);
        if (last != want.last) report_mismatch("last", last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("** deadline_timer_queue: FAILED **");
      $finish;
    end
  end

  initial begin
    dtq_pkg::time_t tmax;
    dtq_pkg::time_t wall;
    tmax = '1;
    wall = 1000;
    for (int i = 0; i < dtq_pkg::TIMER_SLOTS; i++) begin
      phase_of[i]  = PH_IDLE;
      armed[i]     = 1'b0;
      due_at[i]    = '0;
      ticket_of[i] = '0;
    end
    ticket_next = '0;

    add_row(dtq_pkg::CMD_UPDATE, 0,  '0,   '0,   1, dtq_pkg::KIND_NONE_FIRED);
    add_row(dtq_pkg::CMD_CLEAR,  0,  tmax, tmax, 1, dtq_pkg::KIND_NONE_FIRED);
    add_row(dtq_pkg::CMD_STOP,   0,  '0,   '0,   1, dtq_pkg::KIND_STOP_REFUSED);
    add_row(dtq_pkg::CMD_ADD,    0,  '0,   tmax, 1, dtq_pkg::KIND_ADDED);
    add_row(dtq_pkg::CMD_ADD,    31, tmax, '0,   1, dtq_pkg::KIND_ADDED);
    add_row(dtq_pkg::CMD_ADD,    0,  100,  '0,   1, dtq_pkg::KIND_ADD_REJECTED);
    add_row(dtq_pkg::CMD_ADD,    5,  100,  '0,   1, dtq_pkg::KIND_ADDED);
    add_row(dtq_pkg::CMD_STOP,   5,  '0,   '0,   1, dtq_pkg::KIND_STOPPED);
    add_row(dtq_pkg::CMD_STOP,   5,  '0,   '0,   1, dtq_pkg::KIND_STOP_REFUSED);
    add_row(dtq_pkg::CMD_ADD,    7,  100,  '0,   1, dtq_pkg::KIND_ADDED);
    add_row(dtq_pkg::CMD_UPDATE, 0,  '0,   '0,   0, dtq_pkg::KIND_ADDED);
    add_row(dtq_pkg::CMD_ADD,    7,  '0,   '0,   1, dtq_pkg::KIND_ADD_REJECTED);
    add_row(dtq_pkg::CMD_STOP,   7,  '0,   '0,   1, dtq_pkg::KIND_STOPPED);
    add_row(dtq_pkg::CMD_UPDATE, 0,  '0,   99,   1, dtq_pkg::KIND_NONE_FIRED);
    add_row(dtq_pkg::CMD_UPDATE, 0,  '0,   100,  0, dtq_pkg::KIND_ADDED);
    add_row(dtq_pkg::CMD_ADD,    3,  50,   '0,   0, dtq_pkg::KIND_ADDED);
    add_row(dtq_pkg::CMD_ADD,    4,  50,   '0,   0, dtq_pkg::KIND_ADDED);
    add_row(dtq_pkg::CMD_ADD,    2,  40,   '0,   0, dtq_pkg::KIND_ADDED);
    add_row(dtq_pkg::CMD_UPDATE, 0,  '0,   tmax, 0, dtq_pkg::KIND_ADDED);
    add_row(dtq_pkg::CMD_ADD,    1,  10,   '0,   0, dtq_pkg::KIND_ADDED);
    add_row(dtq_pkg::CMD_ADD,    9,  20,   '0,   0, dtq_pkg::KIND_ADDED);
    add_row(dtq_pkg::CMD_UPDATE, 0,  '0,   5,    0, dtq_pkg::KIND_ADDED);
    add_row(dtq_pkg::CMD_ADD,    10, '0,   '0,   0, dtq_pkg::KIND_ADDED);
    add_row(dtq_pkg::CMD_CLEAR,  0,  '0,   '0,   0, dtq_pkg::KIND_ADDED);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_word(plan[i]);
    random_words(RANDOM_PER_PHASE, wall);
    wait_drained();

    idle_pct = 54;
    random_words(RANDOM_PER_PHASE, wall);
    wait_drained();

    idle_pct = 0;
    stall_pct = 54;
    random_words(RANDOM_PER_PHASE, wall);
    wait_drained();

    idle_pct = 36;
    stall_pct = 36;
    random_words(RANDOM_PER_PHASE, wall);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d command words over four idling phases; checked %0d result words,",
             words_sent, results_seen);
    $display("%0d of them timer firings, with %0d mismatches.", fired_seen, errors);
    if (errors == 0) begin
      $display("** deadline_timer_queue: PASSED **");
    end else begin
      $display("** deadline_timer_queue: FAILED **");
    end
    $finish;
  end

endmodule
